// File: design/mspr_pkg.sv
// Shared types and constants for the protection-region slot replacement unit.
package mspr_pkg;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    typedef struct packed {
        logic clear_all;
        logic wr_en;
    } store_cmd_t;

    localparam logic KIND_PUSH       = 1'b0;
    localparam logic KIND_INVALIDATE = 1'b1;

    localparam logic [31:0] BASE_VALID_FLAG = 32'h0000_0010;
    localparam logic [7:0]  PRIO_ZERO       = 8'd0;
    localparam logic [7:0]  PRIO_FLOOR      = 8'd1;

endpackage

// File: design/mspr_prio_store.sv
// Per-slot priority store for the dynamic protection-region slots.
module mspr_prio_store
    import mspr_pkg::*;
#(
    parameter int DEPTH = 5,
    parameter int IDX_W = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  store_cmd_t       cmd,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [7:0]       wr_prio,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_prio
);

    logic [7:0] prio_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                prio_reg[i] <= '0;
            end
        end else if (cmd.clear_all) begin
            for (int i = 0; i < DEPTH; i++) begin
                prio_reg[i] <= '0;
            end
        end else if (cmd.wr_en) begin
            prio_reg[wr_idx] <= wr_prio;
        end
    end

    assign rd_prio = prio_reg[rd_idx];

endmodule

// File: design/mpu_slot_priority_replacement_unit.sv
// Top level of the protection-region slot replacement unit.
// A push steps a single priority comparator over the dynamic slots, one slot per cycle,
// starting after the round-robin pointer, and holds the block until its result enters
// the output register; an invalidate issues N clearing writes, where N is
// TOTAL_SLOTS - FIXED_SLOTS, one per cycle while the result side keeps up. A finished
// result sits in an output register, so a new item may be taken while it waits. With
// no dynamic slots every item is taken and produces nothing.
module mpu_slot_priority_replacement_unit
    import mspr_pkg::*;
#(
    parameter int TOTAL_SLOTS = 8,
    parameter int FIXED_SLOTS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_region_base,
    input  logic [31:0] s_region_attributes,
    input  logic [7:0]  s_priority_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_slot,
    output logic [31:0] m_base_word,
    output logic [31:0] m_attribute_word,
    output logic        m_last
);

    localparam bit HAS_DYN = TOTAL_SLOTS > FIXED_SLOTS;
    localparam int DYN_N   = HAS_DYN ? TOTAL_SLOTS - FIXED_SLOTS : 1;
    localparam int IDX_W   = (DYN_N > 1) ? $clog2(DYN_N) : 1;
    localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DYN_N - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       base_reg, base_next;
    logic [31:0]       attr_reg, attr_next;
    logic [7:0]        prio_reg, prio_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_slot_reg, m_slot_next;
    logic [31:0]       m_base_reg, m_base_next;
    logic [31:0]       m_attr_reg, m_attr_next;
    logic              m_last_reg, m_last_next;

    store_cmd_t        store_cmd;
    logic [IDX_W-1:0]  cand_idx;
    logic [IDX_W-1:0]  sel_idx;
    logic [7:0]        rd_prio;
    logic              hit;
    logic              out_free;
    logic [SLOT_W-1:0] slot_val;
    logic [31:0]       slot_word;

    mspr_prio_store #(
        .DEPTH (DYN_N),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (store_cmd),
        .wr_idx  (cand_idx),
        .wr_prio (prio_reg),
        .rd_idx  (cand_idx),
        .rd_prio (rd_prio)
    );

    assign cand_idx  = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
    assign sel_idx   = (state_reg == ST_CLEAR) ? idx_reg : cand_idx;
    assign slot_val  = SLOT_W'(FIXED_SLOTS) + SLOT_W'(sel_idx);
    assign slot_word = 32'(slot_val);
    assign hit       = rd_prio < prio_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        attr_next    = attr_reg;
        prio_next    = prio_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_slot_next  = m_slot_reg;
        m_base_next  = m_base_reg;
        m_attr_next  = m_attr_reg;
        m_last_next  = m_last_reg;
        store_cmd    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && HAS_DYN) begin
                    if (s_kind == KIND_INVALIDATE) begin
                        store_cmd.clear_all = 1'b1;
                        ptr_next            = '0;
                        idx_next            = '0;
                        state_next          = ST_CLEAR;
                    end else begin
                        base_next  = s_region_base;
                        attr_next  = s_region_attributes;
                        prio_next  = (s_priority_req == PRIO_ZERO) ? PRIO_FLOOR
                                                                    : s_priority_req;
                        idx_next   = ptr_reg;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || cnt_reg == IDX_LAST) begin
                    if (out_free) begin
                        store_cmd.wr_en = 1'b1;
                        ptr_next        = cand_idx;
                        m_valid_next    = 1'b1;
                        m_slot_next     = slot_word[2:0];
                        m_base_next     = base_reg | slot_word | BASE_VALID_FLAG;
                        m_attr_next     = attr_reg;
                        m_last_next     = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    idx_next = cand_idx;
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_CLEAR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_slot_next  = slot_word[2:0];
                    m_base_next  = '0;
                    m_attr_next  = '0;
                    m_last_next  = (idx_reg == IDX_LAST);
                    if (idx_reg == IDX_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        attr_reg   <= attr_next;
        prio_reg   <= prio_next;
        m_slot_reg <= m_slot_next;
        m_base_reg <= m_base_next;
        m_attr_reg <= m_attr_next;
        m_last_reg <= m_last_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_slot           = m_slot_reg;
    assign m_base_word      = m_base_reg;
    assign m_attribute_word = m_attr_reg;
    assign m_last           = m_last_reg;

`ifndef SYNTHESIS
    a_clear_zero_attr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_base_word[4] |-> m_attribute_word == '0)
        else $error("Clearing write carries non-zero attributes.");

    a_clear_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("Clearing sequence stalled after a non-final transfer.");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> ptr_reg <= IDX_LAST)
        else $error("Round-robin pointer outside the dynamic slots.");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the protection-region slot replacement unit.
module tb_top
    import mspr_pkg::*;
();

    localparam int TOTAL = 8;
    localparam int FIXED = 3;
    localparam int N_DYN = TOTAL - FIXED;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;
    localparam int N_DIRECTED = 16;

    typedef struct packed {
        bit [2:0]  slot;
        bit [31:0] base_word;
        bit [31:0] attribute_word;
        bit        last;
    } slot_write_t;

    typedef struct packed {
        bit        kind;
        bit [31:0] region_base;
        bit [31:0] region_attributes;
        bit [7:0]  priority_req;
        bit        typed;
        bit [2:0]  want_slot;
        bit [31:0] want_base;
        bit [31:0] want_attr;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [31:0] s_region_base;
    logic [31:0] s_region_attributes;
    logic [7:0]  s_priority_req;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_slot;
    logic [31:0] m_base_word;
    logic [31:0] m_attribute_word;
    logic        m_last;

    slot_write_t pending_writes[$];
    slot_write_t step_writes[$];
    bit [7:0]    held_priority [N_DYN];
    int unsigned rr_slot;

    int  fail_count;
    int  pushes_sent;
    int  invalidates_sent;
    int  writes_checked;
    int  start_overwrites;
    int  items_offered;
    int  idle_cycles;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  no_idle;
    bit  long_hold_req;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{KIND_PUSH, 32'h0000_0000, 32'h0000_0000, PRIO_ZERO, 1'b1,
          3'd4, 32'h0000_0014, 32'h0000_0000},
        '{KIND_PUSH, 32'hFFFF_FFE0, 32'hFFFF_FFFF, 8'd255, 1'b1,
          3'd5, 32'hFFFF_FFF5, 32'hFFFF_FFFF},
        '{KIND_PUSH, 32'h0000_001F, 32'hA5A5_A5A5, 8'd1, 1'b1,
          3'd6, 32'h0000_001F, 32'hA5A5_A5A5},
        '{KIND_PUSH, 32'h0000_0100, 32'h5A5A_5A5A, 8'd255, 1'b0, 3'd0, 32'h0, 32'h0},
        '{KIND_PUSH, 32'h0000_0200, 32'h0000_FFFF, 8'd255, 1'b0, 3'd0, 32'h0, 32'h0},
        '{KIND_PUSH, 32'h0000_0300, 32'hFFFF_0000, 8'd255, 1'b0, 3'd0, 32'h0, 32'h0},
        '{KIND_PUSH, 32'h0000_0400, 32'h1234_5678, 8'd255, 1'b0, 3'd0, 32'h0, 32'h0},
        '{KIND_PUSH, 32'h0000_1000, 32'h8765_4321, 8'd255, 1'b1,
          3'd6, 32'h0000_1016, 32'h8765_4321},
        '{KIND_PUSH, 32'h0000_2000, 32'h0F0F_0F0F, PRIO_ZERO, 1'b0, 3'd0, 32'h0, 32'h0},
        '{KIND_INVALIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b0,
          3'd0, 32'h0, 32'h0},
        '{KIND_PUSH, 32'h0000_0040, 32'hC3C3_C3C3, 8'd7, 1'b1,
          3'd4, 32'h0000_0054, 32'hC3C3_C3C3},
        '{KIND_INVALIDATE, 32'h0000_0000, 32'h0000_0000, 8'd0, 1'b0, 3'd0, 32'h0, 32'h0},
        '{KIND_INVALIDATE, 32'hDEAD_BEE0, 32'h0BAD_F00D, 8'd17, 1'b0,
          3'd0, 32'h0, 32'h0},
        '{KIND_PUSH, 32'hFFFF_FFFF, 32'h0000_0000, 8'd128, 1'b1,
          3'd4, 32'hFFFF_FFFF, 32'h0000_0000},
        '{KIND_PUSH, 32'h7FFF_FFE0, 32'h8000_0000, 8'd254, 1'b0, 3'd0, 32'h0, 32'h0},
        '{KIND_PUSH, 32'h8000_0000, 32'h7FFF_FFFF, 8'd2, 1'b0, 3'd0, 32'h0, 32'h0}
    };

    mpu_slot_priority_replacement_unit #(
        .TOTAL_SLOTS(TOTAL),
        .FIXED_SLOTS(FIXED)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_region_base(s_region_base),
        .s_region_attributes(s_region_attributes),
        .s_priority_req(s_priority_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_slot(m_slot),
        .m_base_word(m_base_word),
        .m_attribute_word(m_attribute_word),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void predict_writes(bit kind, bit [31:0] base, bit [31:0] attr,
                                           bit [7:0] prio);
        int unsigned scan;
        int unsigned start;
        bit hit;
        bit [7:0] eff;
        step_writes.delete();
        if (kind == KIND_INVALIDATE) begin
            rr_slot = FIXED;
            for (int i = 0; i < N_DYN; i++) begin
                held_priority[i] = 8'd0;
                step_writes.push_back('{slot: 3'(FIXED + i), base_word: 32'h0,
                                        attribute_word: 32'h0, last: (i == N_DYN - 1)});
            end
            return;
        end
        eff = (prio == PRIO_ZERO) ? PRIO_FLOOR : prio;
        start = rr_slot;
        scan = start;
        hit = 1'b0;
        for (int i = 0; i < N_DYN && !hit; i++) begin
            scan++;
            if (scan >= TOTAL)
                scan = FIXED;
            if (held_priority[scan - FIXED] < eff)
                hit = 1'b1;
        end
        if (!hit) begin
            scan = start;
            start_overwrites++;
        end
        rr_slot = scan;
        held_priority[scan - FIXED] = eff;
        step_writes.push_back('{slot: 3'(scan), base_word: base | 32'(scan) | BASE_VALID_FLAG,
                                attribute_word: attr, last: 1'b1});
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        row = '0;
        row.kind = ($urandom_range(0, 99) < 8) ? KIND_INVALIDATE : KIND_PUSH;
        row.region_base = $urandom;
        if ($urandom_range(0, 3) != 0)
            row.region_base[4:0] = 5'd0;
        row.region_attributes = $urandom;
        case ($urandom_range(0, 3))
            0: row.priority_req = 8'($urandom_range(0, 3));
            1: row.priority_req = 8'($urandom_range(0, 255));
            2: row.priority_req = $urandom_range(0, 1) ? 8'd255 : PRIO_ZERO;
            default: row.priority_req = 8'($urandom_range(250, 255));
        endcase
        return row;
    endfunction

    task automatic offer_item(input stim_row_t row);
        s_valid <= 1'b1;
        s_kind <= row.kind;
        s_region_base <= row.region_base;
        s_region_attributes <= row.region_attributes;
        s_priority_req <= row.priority_req;
        do @(posedge aclk); while (!s_ready);
        predict_writes(row.kind, row.region_base, row.region_attributes, row.priority_req);
        if (row.typed)
            pending_writes.push_back('{slot: row.want_slot, base_word: row.want_base,
                                       attribute_word: row.want_attr, last: 1'b1});
        else
            foreach (step_writes[i]) pending_writes.push_back(step_writes[i]);
        if (row.kind == KIND_INVALIDATE)
            invalidates_sent++;
        else
            pushes_sent++;
        items_offered++;
    endtask

    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++) begin
            if (!no_idle && items_offered % 32 == 0) begin
                tx_idle_pct = $urandom_range(0, 2) * 25;
                rx_idle_pct = $urandom_range(0, 2) * 25;
            end
            offer_item(random_row());
            sender_gap();
        end
    endtask

    // Source side.
    initial begin
        s_valid <= 1'b0;
        s_kind <= KIND_PUSH;
        s_region_base <= 32'h0;
        s_region_attributes <= 32'h0;
        s_priority_req <= 8'h0;
        aresetn <= 1'b0;
        rr_slot = FIXED;
        foreach (held_priority[i]) held_priority[i] = 8'd0;
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            offer_item(directed_rows[r]);
            sender_gap();
        end
        run_random(120);

        long_hold_req = 1'b1;
        run_random(40);
        run_random(80);

        s_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        run_random(20);

        no_idle = 1'b1;
        run_random(60);
        s_valid <= 1'b0;

        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (4 * N_DYN + 8) @(posedge aclk);
        if (pending_writes.size() != 0) begin
            $error("%0d expected slot writes never arrived", pending_writes.size());
            fail_count++;
        end
        $display("Run covered %0d pushes and %0d invalidates, with %0d slot writes checked.",
                 pushes_sent, invalidates_sent, writes_checked);
        $display("%0d pushes found no lower-priority slot and overwrote the search start.",
                 start_overwrites);
        if (fail_count == 0)
            $display("mpu_slot_priority_replacement_unit: match");
        else
            $display("mpu_slot_priority_replacement_unit: mismatch");
        $finish;
    end

    // Result side.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 99) < rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        slot_write_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected slot write transfer: slot %0d base %h", m_slot, m_base_word);
                fail_count++;
            end else begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (m_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_slot);
                    fail_count++;
                end
                if (m_base_word !== want.base_word) begin
                    $error("base_word: expected %h, got %h", want.base_word, m_base_word);
                    fail_count++;
                end
                if (m_attribute_word !== want.attribute_word) begin
                    $error("attribute_word: expected %h, got %h", want.attribute_word,
                           m_attribute_word);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timed out with no transfer for %0d cycles.", idle_cycles);
            $display("mpu_slot_priority_replacement_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: files.f
design/mspr_pkg.sv
design/mspr_prio_store.sv
design/mpu_slot_priority_replacement_unit.sv
bench/tb_top.sv
